@@ design/fsms_pkg.sv @@
// shared types, constants and microcode table of the freshness sync scheduler
`timescale 1ns / 1ps

package fsms_pkg;

    // default sizes
    localparam int DEF_ECU_COUNT   = 8;
    localparam int DEF_RESET_COUNT = 4;
    localparam int MAX_RESET_COUNT = 4;

    // word kinds on the slave stream
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    // message kinds
    localparam logic [1:0] KIND_TRIP   = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_NOTIFY = 2'd2;
    localparam logic [1:0] KIND_RESET  = 2'd3;

    // register indexes on the config port
    localparam logic [2:0] REG_WINDOW_TICKS  = 3'd0;
    localparam logic [2:0] REG_RESEND_LIMIT  = 3'd1;
    localparam logic [2:0] REG_TICK_STEP     = 3'd2;
    localparam logic [2:0] REG_RESET_PERIOD0 = 3'd3;
    localparam logic [2:0] REG_RESET_PERIOD1 = 3'd4;
    localparam logic [2:0] REG_RESET_PERIOD2 = 3'd5;
    localparam logic [2:0] REG_RESET_PERIOD3 = 3'd6;

    localparam int CFG_ADDR_W = 5;

    // register reset values
    localparam logic [31:0] RST_WINDOW_TICKS = 32'd10000;
    localparam logic [7:0]  RST_RESEND_LIMIT = 8'd3;
    localparam logic [7:0]  RST_TICK_STEP    = 8'd1;
    localparam logic [31:0] RST_RESET_PERIOD = 32'd1000;

    // configuration seen by the datapath
    typedef struct packed {
        logic [31:0]                           window_ticks;
        logic [7:0]                            resend_limit;
        logic [7:0]                            tick_step;
        logic [MAX_RESET_COUNT-1:0][31:0]      reset_period;
    } cfg_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_ACK,
        OP_FIRST,
        OP_WADD,
        OP_RINC,
        OP_ERROR,
        OP_TRIP,
        OP_NOTIFY,
        OP_TCLR,
        OP_TSTEP,
        OP_FLUSH
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IS_ACK,
        COND_FAILED,
        COND_RPHASE,
        COND_WIN_NE,
        COND_ALL_ACKED,
        COND_RES_NE_LIMIT,
        COND_TIMER_MORE
    } cond_t;

    localparam int STEP_W = 4;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    // program addresses
    localparam logic [STEP_W-1:0] PC_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] PC_DISP   = 4'd1;
    localparam logic [STEP_W-1:0] PC_FIRST  = 4'd2;
    localparam logic [STEP_W-1:0] PC_PHASE  = 4'd3;
    localparam logic [STEP_W-1:0] PC_WADD   = 4'd4;
    localparam logic [STEP_W-1:0] PC_WCMP   = 4'd5;
    localparam logic [STEP_W-1:0] PC_ACKCHK = 4'd6;
    localparam logic [STEP_W-1:0] PC_RINC   = 4'd7;
    localparam logic [STEP_W-1:0] PC_LIMCHK = 4'd8;
    localparam logic [STEP_W-1:0] PC_ERROR  = 4'd9;
    localparam logic [STEP_W-1:0] PC_TRIP   = 4'd10;
    localparam logic [STEP_W-1:0] PC_NOTIFY = 4'd11;
    localparam logic [STEP_W-1:0] PC_TCLR   = 4'd12;
    localparam logic [STEP_W-1:0] PC_TSTEP  = 4'd13;
    localparam logic [STEP_W-1:0] PC_FLUSH  = 4'd14;
    localparam logic [STEP_W-1:0] PC_ACK    = 4'd15;

    // control store
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT:   w = '{op: OP_WAIT,   cond: COND_NEVER,        target: PC_WAIT};
            PC_DISP:   w = '{op: OP_NOP,    cond: COND_IS_ACK,       target: PC_ACK};
            PC_FIRST:  w = '{op: OP_FIRST,  cond: COND_FAILED,       target: PC_FLUSH};
            PC_PHASE:  w = '{op: OP_NOP,    cond: COND_RPHASE,       target: PC_TCLR};
            PC_WADD:   w = '{op: OP_WADD,   cond: COND_NEVER,        target: PC_WAIT};
            PC_WCMP:   w = '{op: OP_NOP,    cond: COND_WIN_NE,       target: PC_FLUSH};
            PC_ACKCHK: w = '{op: OP_NOP,    cond: COND_ALL_ACKED,    target: PC_NOTIFY};
            PC_RINC:   w = '{op: OP_RINC,   cond: COND_NEVER,        target: PC_WAIT};
            PC_LIMCHK: w = '{op: OP_NOP,    cond: COND_RES_NE_LIMIT, target: PC_TRIP};
            PC_ERROR:  w = '{op: OP_ERROR,  cond: COND_ALWAYS,       target: PC_FLUSH};
            PC_TRIP:   w = '{op: OP_TRIP,   cond: COND_ALWAYS,       target: PC_FLUSH};
            PC_NOTIFY: w = '{op: OP_NOTIFY, cond: COND_ALWAYS,       target: PC_FLUSH};
            PC_TCLR:   w = '{op: OP_TCLR,   cond: COND_NEVER,        target: PC_WAIT};
            PC_TSTEP:  w = '{op: OP_TSTEP,  cond: COND_TIMER_MORE,   target: PC_TSTEP};
            PC_FLUSH:  w = '{op: OP_FLUSH,  cond: COND_ALWAYS,       target: PC_WAIT};
            PC_ACK:    w = '{op: OP_ACK,    cond: COND_ALWAYS,       target: PC_WAIT};
            default:   w = '{op: OP_NOP,    cond: COND_ALWAYS,       target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ design/fsms_cfg.sv @@
// configuration register file behind the apb port
`timescale 1ns / 1ps

module fsms_cfg
    import fsms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output cfg_t                  cfg
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        wr_en;
    logic [2:0]  reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_WINDOW_TICKS:  cfg_next.window_ticks    = pwdata;
                REG_RESEND_LIMIT:  cfg_next.resend_limit    = pwdata[7:0];
                REG_TICK_STEP:     cfg_next.tick_step       = pwdata[7:0];
                REG_RESET_PERIOD0: cfg_next.reset_period[0] = pwdata;
                REG_RESET_PERIOD1: cfg_next.reset_period[1] = pwdata;
                REG_RESET_PERIOD2: cfg_next.reset_period[2] = pwdata;
                REG_RESET_PERIOD3: cfg_next.reset_period[3] = pwdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ticks <= RST_WINDOW_TICKS;
            cfg_reg.resend_limit <= RST_RESEND_LIMIT;
            cfg_reg.tick_step    <= RST_TICK_STEP;
            cfg_reg.reset_period <= {MAX_RESET_COUNT{RST_RESET_PERIOD}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_WINDOW_TICKS:  prdata = cfg_reg.window_ticks;
            REG_RESEND_LIMIT:  prdata = {24'd0, cfg_reg.resend_limit};
            REG_TICK_STEP:     prdata = {24'd0, cfg_reg.tick_step};
            REG_RESET_PERIOD0: prdata = cfg_reg.reset_period[0];
            REG_RESET_PERIOD1: prdata = cfg_reg.reset_period[1];
            REG_RESET_PERIOD2: prdata = cfg_reg.reset_period[2];
            REG_RESET_PERIOD3: prdata = cfg_reg.reset_period[3];
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ design/freshness_sync_master_scheduler_unit.sv @@
// top level: microcoded freshness sync scheduler with stream ports and apb config
`timescale 1ns / 1ps

// Takes one word at a time on the slave stream (tick or ECU acknowledge) and
// sends message requests on the master stream, tlast marking the final request
// caused by a word. A 16-step microprogram in a control store runs each word on
// a plain datapath: an acknowledge sets the acked bit of its ECU; a tick in the
// trip phase adds the tick step to the window count and, on a window hit, ends
// in notify, a resend or a failure; a tick after a failure is otherwise ignored;
// a tick in the reset phase steps the reset timers one per cycle, unless the
// output is stalled, through a single 32-bit adder and compare.
// Steps stall where the output register is still held by a stalled consumer.
// The next word is accepted while the last request still waits for tready.
module freshness_sync_master_scheduler_unit
    import fsms_pkg::*;
#(
    parameter int ECU_COUNT   = DEF_ECU_COUNT,
    parameter int RESET_COUNT = DEF_RESET_COUNT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [2:0] ecu_index
    input  logic                  s_axis_tuser,   // [0] cmd
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [1:0] sync_timer
    output logic [1:0]            m_axis_tuser,   // [1:0] msg_kind
    output logic                  m_axis_tlast,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int TIDX_W = (RESET_COUNT > 1) ? $clog2(RESET_COUNT) : 1;

    cfg_t                     cfg;
    uword_t                   uw;

    // sequencer and datapath registers
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     cmd_reg, cmd_next;
    logic [2:0]               ecu_reg, ecu_next;
    logic                     first_sent_reg, first_sent_next;
    logic                     failed_reg, failed_next;
    logic                     rphase_reg, rphase_next;
    logic [31:0]              wcount_reg, wcount_next;
    logic [7:0]               rcount_reg, rcount_next;
    logic [ECU_COUNT-1:0]     acked_reg, acked_next;
    logic [31:0]              timer_reg [RESET_COUNT];
    logic [31:0]              timer_next [RESET_COUNT];
    logic [TIDX_W-1:0]        tidx_reg, tidx_next;
    logic                     found_reg, found_next;

    // pending request, held until its last flag is known
    logic                     pend_valid_reg, pend_valid_next;
    logic [1:0]               pend_kind_reg, pend_kind_next;
    logic [1:0]               pend_idx_reg, pend_idx_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_kind_reg, out_kind_next;
    logic [1:0]               out_idx_reg, out_idx_next;
    logic                     out_last_reg, out_last_next;

    logic                     cond_true;
    logic                     stall;
    logic                     emit;
    logic [1:0]               emit_kind;
    logic [1:0]               emit_idx;
    logic                     out_free;
    logic [31:0]              timer_sum;
    logic                     timer_due;
    logic [1:0]               tidx_ext;

    fsms_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // control word fetch and shared terms
    assign uw        = ucode_rom(step_reg);
    assign tidx_ext  = 2'(tidx_reg);
    assign timer_sum = timer_reg[tidx_reg] + {24'd0, cfg.tick_step};
    assign timer_due = timer_sum >= cfg.reset_period[tidx_ext];
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (uw.op == OP_WAIT);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_idx_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // jump condition
    always_comb
    begin
        unique case (uw.cond)
            COND_NEVER:        cond_true = 1'b0;
            COND_ALWAYS:       cond_true = 1'b1;
            COND_IS_ACK:       cond_true = (cmd_reg == CMD_ACK);
            COND_FAILED:       cond_true = failed_reg;
            COND_RPHASE:       cond_true = rphase_reg;
            COND_WIN_NE:       cond_true = (wcount_reg != cfg.window_ticks);
            COND_ALL_ACKED:    cond_true = &acked_reg;
            COND_RES_NE_LIMIT: cond_true = (rcount_reg != cfg.resend_limit);
            COND_TIMER_MORE:   cond_true = (tidx_reg != TIDX_W'(RESET_COUNT - 1));
            default:           cond_true = 1'b0;
        endcase
    end

    // request emitted by this step, and stall decision
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = KIND_TRIP;
        emit_idx  = 2'd0;
        stall     = 1'b0;
        unique case (uw.op)
            OP_WAIT:   stall = !s_axis_tvalid;
            OP_ERROR:
            begin
                emit      = 1'b1;
                emit_kind = KIND_ERROR;
            end
            OP_TRIP:
            begin
                emit      = 1'b1;
                emit_kind = KIND_TRIP;
            end
            OP_NOTIFY:
            begin
                emit      = 1'b1;
                emit_kind = KIND_NOTIFY;
            end
            OP_TSTEP:
            begin
                emit      = !found_reg && timer_due;
                emit_kind = KIND_RESET;
                emit_idx  = tidx_ext;
            end
            OP_FLUSH:  stall = pend_valid_reg && !out_free;
            default:   stall = 1'b0;
        endcase
        if (emit && pend_valid_reg && !out_free)
        begin
            stall = 1'b1;
        end
    end

    // datapath next values
    always_comb
    begin
        step_next       = step_reg;
        cmd_next        = cmd_reg;
        ecu_next        = ecu_reg;
        first_sent_next = first_sent_reg;
        failed_next     = failed_reg;
        rphase_next     = rphase_reg;
        wcount_next     = wcount_reg;
        rcount_next     = rcount_reg;
        acked_next      = acked_reg;
        timer_next      = timer_reg;
        tidx_next       = tidx_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;

        if (!stall)
        begin
            step_next = cond_true ? uw.target : step_reg + 1'b1;

            unique case (uw.op)
                OP_WAIT:
                begin
                    cmd_next = s_axis_tuser;
                    ecu_next = s_axis_tdata[2:0];
                end
                OP_ACK:
                begin
                    for (int j = 0; j < ECU_COUNT; j++)
                    begin
                        if ({4'd0, ecu_reg} == 7'(j))
                        begin
                            acked_next[j] = 1'b1;
                        end
                    end
                end
                OP_FIRST:
                begin
                    if (!first_sent_reg)
                    begin
                        first_sent_next = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = KIND_TRIP;
                        pend_idx_next   = 2'd0;
                    end
                end
                OP_WADD:   wcount_next = wcount_reg + {24'd0, cfg.tick_step};
                OP_RINC:   rcount_next = rcount_reg + 8'd1;
                OP_ERROR:  failed_next = 1'b1;
                OP_TRIP:   wcount_next = 32'd0;
                OP_NOTIFY:
                begin
                    rphase_next = 1'b1;
                    wcount_next = 32'd0;
                end
                OP_TCLR:
                begin
                    tidx_next  = '0;
                    found_next = 1'b0;
                end
                OP_TSTEP:
                begin
                    timer_next[tidx_reg] = emit ? 32'd0 : timer_sum;
                    if (emit)
                    begin
                        found_next = 1'b1;
                    end
                    tidx_next = tidx_reg + 1'b1;
                end
                default:
                begin
                end
            endcase

            // emit: older pending request goes out as not last
            if (emit)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_idx_next   = pend_idx_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_kind_next  = emit_kind;
                pend_idx_next   = emit_idx;
            end

            // flush: pending request goes out as last
            if (uw.op == OP_FLUSH && pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = pend_kind_reg;
                out_idx_next    = pend_idx_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= PC_WAIT;
            first_sent_reg <= 1'b0;
            failed_reg     <= 1'b0;
            rphase_reg     <= 1'b0;
            wcount_reg     <= 32'd0;
            rcount_reg     <= 8'd0;
            acked_reg      <= '0;
            for (int i = 0; i < RESET_COUNT; i++)
            begin
                timer_reg[i] <= 32'd0;
            end
            tidx_reg       <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            first_sent_reg <= first_sent_next;
            failed_reg     <= failed_next;
            rphase_reg     <= rphase_next;
            wcount_reg     <= wcount_next;
            rcount_reg     <= rcount_next;
            acked_reg      <= acked_next;
            timer_reg      <= timer_next;
            tidx_reg       <= tidx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ecu_reg       <= ecu_next;
        pend_kind_reg <= pend_kind_next;
        pend_idx_reg  <= pend_idx_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
    end

endmodule

@@ bench/tb_freshness_sync_master_scheduler_unit.sv @@
// testbench for the freshness sync scheduler: directed table, random phases, request checker
`timescale 1ns / 1ps

module tb_freshness_sync_master_scheduler_unit;
    import fsms_pkg::*;

    localparam int ECUS          = DEF_ECU_COUNT;
    localparam int TIMERS        = DEF_RESET_COUNT;
    localparam int PLAN_LEN      = 25;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 40;
    localparam int CYCLE_LIMIT   = 600000;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    // one message request as seen on the master stream
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] idx;
        logic       is_last;
    } req_t;

    localparam req_t TRIP_MORE = '{kind: KIND_TRIP, idx: 2'd0, is_last: 1'b0};
    localparam req_t TRIP_DONE = '{kind: KIND_TRIP, idx: 2'd0, is_last: 1'b1};
    localparam req_t NO_REQ    = '0;

    // one row of the directed table: a register write or a word
    typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

    typedef struct packed {
        row_kind_t   what;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        logic        cmd;
        logic [2:0]  ecu;
        logic        typed;
        logic [1:0]  n_typed;
        req_t        want0;
        req_t        want1;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // scheduler shadow: configuration and state
    cfg_t        cfg_now;
    logic        trip_started;
    logic        sync_dead;
    logic        in_reset_phase;
    logic [31:0] win_count;
    logic [7:0]  resend_cnt;
    logic [ECUS-1:0] acked_ecus;
    logic [31:0] reset_timer [TIMERS];
    req_t        req_out [2];

    req_t        req_expect [$];
    int          err_count = 0;
    int unsigned cycle_count = 0;
    logic [2:0]  missing_ecu = 3'd2;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    bit          hold_request = 1'b0;

    freshness_sync_master_scheduler_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_step();
        if ($urandom_range(0, 5) == 0)
            return 8'd255;
        return 8'($urandom_range(1, 4));
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(2, 60);
        endcase
    endfunction

    function automatic logic [31:0] shadow_value(input logic [2:0] idx);
        case (idx)
            REG_WINDOW_TICKS: return cfg_now.window_ticks;
            REG_RESEND_LIMIT: return {24'd0, cfg_now.resend_limit};
            REG_TICK_STEP:    return {24'd0, cfg_now.tick_step};
            default:          return cfg_now.reset_period[idx - REG_RESET_PERIOD0];
        endcase
    endfunction

    // next state and requests of the scheduler for one word, requests land in req_out
    function automatic int step_scheduler(input logic cmd, input logic [2:0] ecu);
        int n;
        n = 0;
        if (cmd == CMD_ACK)
        begin
            if (int'(ecu) < ECUS)
                acked_ecus[ecu] = 1'b1;
            return 0;
        end
        if (!trip_started)
        begin
            req_out[n] = TRIP_MORE;
            n = n + 1;
            trip_started = 1'b1;
        end
        if (!sync_dead && !in_reset_phase)
        begin
            win_count = win_count + cfg_now.tick_step;
            if (win_count == cfg_now.window_ticks)
            begin
                if (&acked_ecus)
                begin
                    req_out[n] = '{kind: KIND_NOTIFY, idx: 2'd0, is_last: 1'b0};
                    n = n + 1;
                    in_reset_phase = 1'b1;
                    win_count = '0;
                end
                else
                begin
                    resend_cnt = resend_cnt + 8'd1;
                    if (resend_cnt == cfg_now.resend_limit)
                    begin
                        // window count is left as it is on error
                        req_out[n] = '{kind: KIND_ERROR, idx: 2'd0, is_last: 1'b0};
                        n = n + 1;
                        sync_dead = 1'b1;
                    end
                    else
                    begin
                        req_out[n] = TRIP_MORE;
                        n = n + 1;
                        win_count = '0;
                    end
                end
            end
        end
        else if (!sync_dead)
        begin
            // every timer advances, the lowest due one fires and restarts
            for (int i = 0; i < TIMERS; i++)
                reset_timer[i] = reset_timer[i] + cfg_now.tick_step;
            for (int i = 0; i < TIMERS; i++)
            begin
                if (reset_timer[i] >= cfg_now.reset_period[i])
                begin
                    req_out[n] = '{kind: KIND_RESET, idx: 2'(i), is_last: 1'b0};
                    n = n + 1;
                    reset_timer[i] = '0;
                    break;
                end
            end
        end
        if (n > 0)
            req_out[n-1].is_last = 1'b1;
        return n;
    endfunction

    // one apb transfer, after which the bus goes idle
    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] got;
        apb_access(1'b0, idx, 32'd0, got);
        if (got !== shadow_value(idx))
            note_mismatch($sformatf("register %0d", idx), shadow_value(idx), got);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] unused_rd;
        apb_access(1'b1, idx, value, unused_rd);
        case (idx)
            REG_WINDOW_TICKS: cfg_now.window_ticks = value;
            REG_RESEND_LIMIT: cfg_now.resend_limit = value[7:0];
            REG_TICK_STEP:    cfg_now.tick_step = value[7:0];
            REG_RESET_PERIOD0, REG_RESET_PERIOD1, REG_RESET_PERIOD2, REG_RESET_PERIOD3:
                cfg_now.reset_period[idx - REG_RESET_PERIOD0] = value;
            default: ;
        endcase
        if (idx <= REG_RESET_PERIOD3)
            check_reg(idx);
    endtask

    // offer one word, predict its requests once it is taken
    task automatic send_word(input row_t r);
        int gap;
        int n;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, r.ecu};
        s_axis_tuser  <= r.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n = step_scheduler(r.cmd, r.ecu);
        if (r.typed)
        begin
            if (r.n_typed > 0)
                req_expect.push_back(r.want0);
            if (r.n_typed > 1)
                req_expect.push_back(r.want1);
        end
        else
        begin
            for (int k = 0; k < n; k++)
                req_expect.push_back(req_out[k]);
        end
    endtask

    // drains the request queue and lets any word with no request finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (req_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic row_t cfg_row(input logic [2:0] idx, input logic [31:0] value);
        row_t r;
        r = '0;
        r.what = ROW_CFG;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic row_t word_row(input logic cmd, input logic [2:0] ecu);
        row_t r;
        r = '0;
        r.what = ROW_WORD;
        r.cmd = cmd;
        r.ecu = ecu;
        return r;
    endfunction

    function automatic row_t typed_row(input logic cmd, input logic [2:0] ecu,
                                       input logic [1:0] n, input req_t w0, input req_t w1);
        row_t r;
        r = word_row(cmd, ecu);
        r.typed = 1'b1;
        r.n_typed = n;
        r.want0 = w0;
        r.want1 = w1;
        return r;
    endfunction

    // random word: tick with the given percentage, else an acknowledge
    task automatic push_random(input bit allow_missing, input int tick_pct);
        logic [2:0] ecu;
        do
            ecu = 3'($urandom_range(0, 7));
        while (!allow_missing && ecu == missing_ecu);
        if ($urandom_range(0, 99) < tick_pct)
            send_word(word_row(CMD_TICK, ecu));
        else
            send_word(word_row(CMD_ACK, ecu));
    endtask

    // step and a window that the count reaches from where it stands
    task automatic arm_window(input logic [7:0] step);
        write_reg(REG_TICK_STEP, {24'd0, step});
        write_reg(REG_WINDOW_TICKS, win_count + step * $urandom_range(1, 6));
    endtask

    // sink ready with random stalls and one long hold on request
    initial
    begin : sink_ready
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && !rx_steady && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // request checker
    always @(posedge clk)
    begin : req_check
        req_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (req_expect.size() == 0)
                note_mismatch("unexpected request word", 32'd0,
                              {21'd0, m_axis_tlast, m_axis_tuser, m_axis_tdata});
            else
            begin
                want = req_expect.pop_front();
                if (m_axis_tuser !== want.kind)
                    note_mismatch("msg_kind", want.kind, m_axis_tuser);
                if (m_axis_tdata[1:0] !== want.idx)
                    note_mismatch("sync_timer", want.idx, m_axis_tdata[1:0]);
                if (m_axis_tlast !== want.is_last)
                    note_mismatch("tlast", want.is_last, m_axis_tlast);
            end
        end
    end

    initial
    begin : stimulus
        row_t plan [PLAN_LEN];
        int i;
        int p;
        logic [7:0] limit_val;
        bit error_end;

        cfg_now.window_ticks = RST_WINDOW_TICKS;
        cfg_now.resend_limit = RST_RESEND_LIMIT;
        cfg_now.tick_step    = RST_TICK_STEP;
        for (i = 0; i < MAX_RESET_COUNT; i++)
            cfg_now.reset_period[i] = RST_RESET_PERIOD;
        trip_started   = 1'b0;
        sync_dead      = 1'b0;
        in_reset_phase = 1'b0;
        win_count      = '0;
        resend_cnt     = '0;
        acked_ecus     = '0;
        for (i = 0; i < TIMERS; i++)
            reset_timer[i] = '0;

        // directed table
        plan[0]  = cfg_row(REG_RESEND_LIMIT, 32'd255);
        plan[1]  = cfg_row(REG_WINDOW_TICKS, 32'd1);
        // first tick with the window already reached gives two trips
        plan[2]  = typed_row(CMD_TICK, 3'd0, 2'd2, TRIP_MORE, TRIP_DONE);
        plan[3]  = typed_row(CMD_ACK, 3'd0, 2'd0, NO_REQ, NO_REQ);
        plan[4]  = typed_row(CMD_ACK, 3'd7, 2'd0, NO_REQ, NO_REQ);
        plan[5]  = cfg_row(REG_TICK_STEP, 32'd255);
        plan[6]  = cfg_row(REG_WINDOW_TICKS, 32'd255);
        plan[7]  = typed_row(CMD_TICK, 3'd0, 2'd1, TRIP_DONE, NO_REQ);
        plan[8]  = cfg_row(REG_TICK_STEP, 32'd1);
        plan[9]  = cfg_row(REG_WINDOW_TICKS, 32'd3);
        plan[10] = word_row(CMD_TICK, 3'd0);
        plan[11] = word_row(CMD_ACK, 3'd3);
        plan[12] = word_row(CMD_TICK, 3'd7);
        plan[13] = word_row(CMD_TICK, 3'd0);
        // step of two walks past a window of three
        plan[14] = cfg_row(REG_TICK_STEP, 32'd2);
        plan[15] = word_row(CMD_TICK, 3'd0);
        plan[16] = word_row(CMD_TICK, 3'd0);
        plan[17] = cfg_row(REG_WINDOW_TICKS, 32'd6);
        plan[18] = word_row(CMD_TICK, 3'd0);
        plan[19] = word_row(CMD_ACK, 3'd5);
        plan[20] = cfg_row(REG_WINDOW_TICKS, 32'hFFFF_FFFF);
        plan[21] = word_row(CMD_TICK, 3'd0);
        plan[22] = word_row(CMD_ACK, 3'd1);
        plan[23] = cfg_row(REG_RESEND_LIMIT, 32'd1);
        // write past the last register is ignored
        plan[24] = cfg_row(REG_UNUSED, 32'hFFFF_FFFF);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        for (i = 0; i <= REG_RESET_PERIOD3; i++)
            check_reg(3'(i));

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].what == ROW_CFG)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].value);
            end
            else
                send_word(plan[i]);
        end

        // one ecu stays silent through the trip phase
        missing_ecu = 3'(2 * $urandom_range(1, 3));
        error_end = ($urandom_range(0, 3) == 0);

        // trip phase: resends with a limit kept far away
        for (p = 0; p < (error_end ? 7 : 4); p++)
        begin
            wait_idle();
            arm_window(pick_step());
            do
                limit_val = 8'($urandom_range(1, 255));
            while (8'(limit_val - resend_cnt) < 8'd100);
            write_reg(REG_RESEND_LIMIT, {24'd0, limit_val});
            write_reg(3'(REG_RESET_PERIOD0 + p % TIMERS), pick_period());
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat (60) push_random(1'b0, 70);
        end

        if (error_end)
        begin
            // resend limit one away, then ticks that are ignored after the error
            wait_idle();
            limit_val = resend_cnt + 8'd1;
            if (limit_val == 8'd0)
                limit_val = 8'd1;
            write_reg(REG_RESEND_LIMIT, {24'd0, limit_val});
            arm_window(pick_step());
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            repeat (60) push_random(1'b0, 85);
        end
        else
        begin
            // last ecu answers, the next window hit moves on to the reset phase
            wait_idle();
            arm_window(pick_step());
            send_word(word_row(CMD_ACK, missing_ecu));
            while (!in_reset_phase)
                send_word(word_row(CMD_TICK, 3'd0));
            for (p = 0; p < 4; p++)
            begin
                wait_idle();
                write_reg(REG_TICK_STEP, {24'd0, pick_step()});
                for (i = 0; i < TIMERS; i++)
                    write_reg(3'(REG_RESET_PERIOD0 + i), pick_period());
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
                if (p == 0)
                begin
                    // sink holds off while words keep coming, the block backs up
                    tx_steady = 1'b1;
                    hold_request = 1'b1;
                end
                repeat (65) push_random(1'b1, 80);
            end
        end

        wait_idle();
        if (err_count == 0 && req_expect.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
